FILE: design/psdc_pkg.sv
// Shared types and constants of the PID speed and duty controller.
package psdc_pkg;

  localparam int FRAC_BITS = 20;
  localparam int GAIN_W    = 24;
  localparam int LIMIT_W   = 15;
  localparam int SPEED_W   = 16;
  localparam int INTEG_W   = 32;
  localparam int DUTY_W    = 16;
  localparam int ERR_W     = SPEED_W + 1;
  localparam int CFG_W     = 24;
  localparam int SUM_W     = 59;
  localparam int INC_W     = SUM_W - FRAC_BITS;
  localparam int NEXT_W    = INC_W + 1;

  localparam logic [DUTY_W-1:0]        STALL_LIMIT = 16'd2000;
  localparam logic signed [INC_W-1:0] STOP_STEP   = 39'sd400;

  typedef enum logic [1:0] {
    CFG_KP_GAIN    = 2'd0,
    CFG_KI_GAIN    = 2'd1,
    CFG_KD_GAIN    = 2'd2,
    CFG_DUTY_LIMIT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp_gain;
    logic [GAIN_W-1:0]  ki_gain;
    logic [GAIN_W-1:0]  kd_gain;
    logic [LIMIT_W-1:0] duty_limit;
  } psdc_cfg_t;

  typedef struct packed {
    logic signed [DUTY_W-1:0] duty;
    logic                     held;
    logic                     saturated;
  } psdc_res_t;

endpackage

FILE: design/psdc_law.sv
// Control law of one tick: hold checks, PID increment, stop ramp and duty clamp.
module psdc_law (
  input  psdc_pkg::psdc_cfg_t                      cfg,
  input  logic signed [psdc_pkg::SPEED_W-1:0]      target_speed,
  input  logic signed [psdc_pkg::SPEED_W-1:0]      measured_speed,
  input  logic signed [psdc_pkg::INTEG_W-1:0]      integral_sum,
  input  logic signed [psdc_pkg::DUTY_W-1:0]       duty_cur,
  input  logic signed [psdc_pkg::ERR_W-1:0]        prev_error,
  output psdc_pkg::psdc_res_t                      res,
  output logic signed [psdc_pkg::ERR_W-1:0]        error
);

  logic signed [psdc_pkg::ERR_W:0]          derr;
  logic signed [41:0]                       p_kp;
  logic signed [56:0]                       p_ki;
  logic signed [42:0]                       p_kd;
  logic signed [psdc_pkg::SUM_W-1:0]        sum;
  logic signed [psdc_pkg::SUM_W-1:0]        biased;
  logic signed [psdc_pkg::INC_W-1:0]        inc;
  logic signed [psdc_pkg::NEXT_W-1:0]       next;
  logic signed [psdc_pkg::NEXT_W-1:0]       lim;
  logic [psdc_pkg::DUTY_W-1:0]              mag;
  logic                                     held;

  always_comb begin
    error = psdc_pkg::ERR_W'(target_speed) - psdc_pkg::ERR_W'(measured_speed);
    derr  = (psdc_pkg::ERR_W+1)'(error) - (psdc_pkg::ERR_W+1)'(prev_error);

    p_kp = $signed({1'b0, cfg.kp_gain}) * error;
    p_ki = $signed({1'b0, cfg.ki_gain}) * integral_sum;
    p_kd = $signed({1'b0, cfg.kd_gain}) * derr;
    sum  = psdc_pkg::SUM_W'(p_kp) + psdc_pkg::SUM_W'(p_ki) + psdc_pkg::SUM_W'(p_kd);

    // bias negative sums so the shift truncates toward zero
    biased = sum + (sum[psdc_pkg::SUM_W-1] ?
             psdc_pkg::SUM_W'((64'd1 << psdc_pkg::FRAC_BITS) - 64'd1) : '0);
    inc = biased[psdc_pkg::SUM_W-1:psdc_pkg::FRAC_BITS];

    // stop ramp: fixed step towards the sign of the sum
    if (target_speed == '0) begin
      if (sum[psdc_pkg::SUM_W-1]) begin
        inc = -psdc_pkg::STOP_STEP;
      end else if (sum != '0) begin
        inc = psdc_pkg::STOP_STEP;
      end else begin
        inc = '0;
      end
    end

    next = psdc_pkg::NEXT_W'(duty_cur) + psdc_pkg::NEXT_W'(inc);
    lim  = $signed(psdc_pkg::NEXT_W'(cfg.duty_limit));
    res.saturated = 1'b0;
    if (next > lim) begin
      next          = lim;
      res.saturated = 1'b1;
    end else if (next < -lim) begin
      next          = -lim;
      res.saturated = 1'b1;
    end

    mag  = duty_cur[psdc_pkg::DUTY_W-1] ? psdc_pkg::DUTY_W'(-duty_cur)
                                        : psdc_pkg::DUTY_W'(duty_cur);
    held = ((target_speed == '0) && (duty_cur == '0)) ||
           ((measured_speed == '0) && (mag > psdc_pkg::STALL_LIMIT));

    res.held = held;
    res.duty = next[psdc_pkg::DUTY_W-1:0];
    if (held) begin
      res.duty      = duty_cur;
      res.saturated = 1'b0;
    end
  end

endmodule

FILE: design/pid_speed_duty_controller.sv
// Top level of the incremental PID speed controller with signed duty output.
//
// Each input beat is one control tick: target speed, measured speed and an
// externally kept integral sum. Each tick gives exactly one result beat with
// the new duty, a held flag (tick skipped, duty unchanged) and a saturated
// flag (duty clamped to plus or minus the duty limit).
// A tick sits in the input register after its input beat; the control law
// runs from there into the result register, which holds the result beat.
// One beat is taken every cycle while the receiver does not stall; the rate
// is set by the loop through the duty and previous-error registers, which
// the combinational control law closes. When the receiver stalls the result
// register holds its beat; the input register still takes a beat while it
// is empty or is about to move on, and once both registers are full ready
// drops until the stall clears. Gains and the duty limit must be written
// by the user through the cfg_ port only while idle; the block does not
// enforce it. Reset clears duty and previous error, loads the default gains
// (0.6, 0.0002, 0.001 in Q4.20), a limit of 10000 and empties both registers.
module pid_speed_duty_controller (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [psdc_pkg::SPEED_W-1:0]     in_target_speed,
  input  logic signed [psdc_pkg::SPEED_W-1:0]     in_measured_speed,
  input  logic signed [psdc_pkg::INTEG_W-1:0]     in_integral_sum,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [psdc_pkg::DUTY_W-1:0]      out_duty,
  output logic                                    out_held,
  output logic                                    out_saturated,
  input  logic                                    cfg_we,
  input  logic [1:0]                              cfg_index,
  input  logic [psdc_pkg::CFG_W-1:0]              cfg_data
);

  psdc_pkg::psdc_cfg_t                       cfg_r;
  logic                                      in_v_r;
  logic signed [psdc_pkg::SPEED_W-1:0]       tgt_r;
  logic signed [psdc_pkg::SPEED_W-1:0]       meas_r;
  logic signed [psdc_pkg::INTEG_W-1:0]       integ_r;
  logic                                      out_v_r;
  psdc_pkg::psdc_res_t                       res_r;
  logic signed [psdc_pkg::DUTY_W-1:0]        duty_r;
  logic signed [psdc_pkg::ERR_W-1:0]         prev_err_r;
  psdc_pkg::psdc_res_t                       res_nxt;
  logic signed [psdc_pkg::ERR_W-1:0]         err_nxt;
  logic                                      advance;

  psdc_law u_law (
    .cfg            (cfg_r),
    .target_speed   (tgt_r),
    .measured_speed (meas_r),
    .integral_sum   (integ_r),
    .duty_cur       (duty_r),
    .prev_error     (prev_err_r),
    .res            (res_nxt),
    .error          (err_nxt)
  );

  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  assign out_valid     = out_v_r;
  assign out_duty      = res_r.duty;
  assign out_held      = res_r.held;
  assign out_saturated = res_r.saturated;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain    <= 24'd629146;
      cfg_r.ki_gain    <= 24'd210;
      cfg_r.kd_gain    <= 24'd1049;
      cfg_r.duty_limit <= 15'd10000;
    end else if (cfg_we) begin
      case (psdc_pkg::cfg_idx_t'(cfg_index))
        psdc_pkg::CFG_KP_GAIN:    cfg_r.kp_gain    <= cfg_data;
        psdc_pkg::CFG_KI_GAIN:    cfg_r.ki_gain    <= cfg_data;
        psdc_pkg::CFG_KD_GAIN:    cfg_r.kd_gain    <= cfg_data;
        psdc_pkg::CFG_DUTY_LIMIT: cfg_r.duty_limit <= cfg_data[psdc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tgt_r   <= in_target_speed;
      meas_r  <= in_measured_speed;
      integ_r <= in_integral_sum;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // controller state moves only on ticks that are not held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r     <= '0;
      prev_err_r <= '0;
    end else if (advance && !res_nxt.held) begin
      duty_r     <= res_nxt.duty;
      prev_err_r <= err_nxt;
    end
  end

endmodule
